[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clock and quiet in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hw/rtl/wsfp_pkg.sv]
// ----------------------------------------------------------------------------
// wsfp_pkg
// Types and constants shared by the WebSocket frame parser modules.
// ----------------------------------------------------------------------------
`default_nettype none

package wsfp_pkg;

   // Default width of the payload length counter
   localparam int LENGTH_BITS_DEF = 64;

   // Header byte fields
   localparam int FIN_BIT  = 7;
   localparam int MASK_BIT = 7;

   // Seven-bit length codes that announce an extended length
   localparam logic [6:0] LEN_CODE_EXT16 = 7'd126;
   localparam logic [6:0] LEN_CODE_EXT64 = 7'd127;

   // Header bytes still to come in the field after its first byte
   localparam logic [2:0] EXT16_BYTES_LEFT = 3'd1;
   localparam logic [2:0] EXT64_BYTES_LEFT = 3'd7;
   localparam logic [2:0] KEY_BYTES_LEFT   = 3'd3;

   // One result beat
   typedef struct packed {
      logic       valid;
      logic [7:0] payload_byte;
      logic       final_fragment;
      logic [3:0] frame_opcode;
      logic       end_of_frame;
      logic       empty_frame;
   } result_type;

endpackage

`default_nettype wire

[hw/rtl/wsfp_parse.sv]
// ----------------------------------------------------------------------------
// wsfp_parse
// Frame state machine: consumes one byte per step and forms the result beat.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module wsfp_parse #(
   parameter int LENGTH_BITS = wsfp_pkg::LENGTH_BITS_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 step_en,
   input  wire logic [7:0]           rx_byte,
   output wsfp_pkg::result_type      res
);

   typedef enum logic [2:0] {
      PH_HDR0 = 3'd0,
      PH_HDR1 = 3'd1,
      PH_EXT  = 3'd2,
      PH_KEY  = 3'd3,
      PH_DATA = 3'd4
   } phase_type;

   phase_type              phase_ff, phase_in;
   logic [LENGTH_BITS-1:0] rem_ff, rem_in;
   logic [2:0]             cnt_ff, cnt_in;
   logic [31:0]            key_ff, key_in;
   logic [1:0]             idx_ff, idx_in;
   logic                   masked_ff, masked_in;
   logic                   fin_ff, fin_in;
   logic [3:0]             opcode_ff, opcode_in;

   // Work out next state and the result for the current byte
   always_comb begin
      logic                   len_known;
      logic                   hdr_end;
      logic [LENGTH_BITS-1:0] len_v;
      logic [7:0]             key_byte;

      len_known = 1'b0;
      hdr_end   = 1'b0;
      len_v     = rem_ff;
      key_byte  = 8'h00;

      phase_in  = phase_ff;
      rem_in    = rem_ff;
      cnt_in    = cnt_ff;
      key_in    = key_ff;
      idx_in    = idx_ff;
      masked_in = masked_ff;
      fin_in    = fin_ff;
      opcode_in = opcode_ff;

      res                = '0;
      res.final_fragment = fin_ff;
      res.frame_opcode   = opcode_ff;

      unique case (phase_ff)
         PH_HDR1: begin
            masked_in = rx_byte[wsfp_pkg::MASK_BIT];
            if (rx_byte[6:0] == wsfp_pkg::LEN_CODE_EXT16) begin
               rem_in   = '0;
               cnt_in   = wsfp_pkg::EXT16_BYTES_LEFT;
               phase_in = PH_EXT;
            end else if (rx_byte[6:0] == wsfp_pkg::LEN_CODE_EXT64) begin
               rem_in   = '0;
               cnt_in   = wsfp_pkg::EXT64_BYTES_LEFT;
               phase_in = PH_EXT;
            end else begin
               len_v     = LENGTH_BITS'(rx_byte[6:0]);
               rem_in    = len_v;
               len_known = 1'b1;
            end
         end
         PH_EXT: begin
            len_v  = {rem_ff[LENGTH_BITS-9:0], rx_byte};
            rem_in = len_v;
            if (cnt_ff != 3'd0) begin
               cnt_in = cnt_ff - 3'd1;
            end else begin
               len_known = 1'b1;
            end
         end
         PH_KEY: begin
            key_in = {key_ff[23:0], rx_byte};
            if (cnt_ff != 3'd0) begin
               cnt_in = cnt_ff - 3'd1;
            end else begin
               hdr_end = 1'b1;
            end
         end
         PH_DATA: begin
            case (idx_ff)
               2'd0:    key_byte = key_ff[31:24];
               2'd1:    key_byte = key_ff[23:16];
               2'd2:    key_byte = key_ff[15:8];
               default: key_byte = key_ff[7:0];
            endcase
            if (!masked_ff) begin
               key_byte = 8'h00;
            end
            idx_in           = idx_ff + 2'd1;
            rem_in           = rem_ff - LENGTH_BITS'(1);
            res.valid        = 1'b1;
            res.payload_byte = rx_byte ^ key_byte;
            if (rem_in == '0) begin
               res.end_of_frame = 1'b1;
               phase_in         = PH_HDR0;
            end
         end
         default: begin
            fin_in    = rx_byte[wsfp_pkg::FIN_BIT];
            opcode_in = rx_byte[3:0];
            phase_in  = PH_HDR1;
         end
      endcase

      // Length known: fetch the mask key, or close the header
      if (len_known) begin
         if (masked_in) begin
            cnt_in   = wsfp_pkg::KEY_BYTES_LEFT;
            key_in   = '0;
            phase_in = PH_KEY;
         end else begin
            hdr_end = 1'b1;
         end
      end

      // Header closed: enter payload, or report an empty frame
      if (hdr_end) begin
         idx_in = 2'd0;
         if (len_v == '0) begin
            res.valid        = 1'b1;
            res.end_of_frame = 1'b1;
            res.empty_frame  = 1'b1;
            phase_in         = PH_HDR0;
         end else begin
            phase_in = PH_DATA;
         end
      end
   end

   // Hold parse state; advance on each consumed byte
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HDR0;
         rem_ff    <= '0;
         cnt_ff    <= '0;
         key_ff    <= '0;
         idx_ff    <= '0;
         masked_ff <= 1'b0;
         fin_ff    <= 1'b0;
         opcode_ff <= '0;
      end else if (step_en) begin
         phase_ff  <= phase_in;
         rem_ff    <= rem_in;
         cnt_ff    <= cnt_in;
         key_ff    <= key_in;
         idx_ff    <= idx_in;
         masked_ff <= masked_in;
         fin_ff    <= fin_in;
         opcode_ff <= opcode_in;
      end
   end

   `ASSERT_IMPLIES(a_data_len_nonzero, phase_ff == PH_DATA, rem_ff != '0, "payload phase with zero length")
   `ASSERT_IMPLIES(a_key_count, phase_ff == PH_KEY, cnt_ff <= wsfp_pkg::KEY_BYTES_LEFT, "mask key count out of range")
   `ASSERT_IMPLIES(a_empty_shape, res.valid && res.empty_frame, res.end_of_frame && (res.payload_byte == 8'h00), "empty frame beat malformed")

endmodule

`default_nettype wire

[hw/rtl/websocket_frame_parser_core.sv]
// ----------------------------------------------------------------------------
// websocket_frame_parser_core
// Receive-side WebSocket frame parser: byte stream in, unmasked payload out.
// ----------------------------------------------------------------------------
//  channel | ports                                              | direction
//  req     | req_valid, req_stall, req_rx_byte                  | in
//  rsp     | rsp_valid, rsp_stall, rsp_payload_byte,            | out
//          | rsp_final_fragment, rsp_frame_opcode,              |
//          | rsp_end_of_frame, rsp_empty_frame                  |
//
//  One byte per clock sustained while rsp is not stalled; a byte is held in the
//  input register, then the parse step loads its beat into the result register,
//  from which the beat is offered on rsp.
//  Header and mask key bytes give no rsp beat; each payload byte and each
//  empty frame give one.
//  Reset is synchronous and returns the parser to the first header byte.
//  A stalled rsp beat holds; the input register still takes one byte.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module websocket_frame_parser_core #(
   parameter int LENGTH_BITS = wsfp_pkg::LENGTH_BITS_DEF
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_rx_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [7:0]      rsp_payload_byte,
   output logic            rsp_final_fragment,
   output logic [3:0]      rsp_frame_opcode,
   output logic            rsp_end_of_frame,
   output logic            rsp_empty_frame
);

   logic                 in_valid_ff;
   logic [7:0]           in_byte_ff;
   logic                 out_valid_ff;
   wsfp_pkg::result_type out_ff;
   wsfp_pkg::result_type step_res;
   logic                 advance;
   logic                 req_take;

   // Parse step runs when the result slot is free or being emptied
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   wsfp_parse #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_parse (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .rx_byte (in_byte_ff),
      .res     (step_res)
   );

   // Capture an incoming beat; drop the slot once consumed
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_take) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_rx_byte;
      end
   end

   // Load the result register; clear it once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= step_res.valid;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && step_res.valid) begin
         out_ff <= step_res;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_payload_byte   = out_ff.payload_byte;
   assign rsp_final_fragment = out_ff.final_fragment;
   assign rsp_frame_opcode   = out_ff.frame_opcode;
   assign rsp_end_of_frame   = out_ff.end_of_frame;
   assign rsp_empty_frame    = out_ff.empty_frame;

   `ASSERT_NEXT(a_in_hold, in_valid_ff && !advance, in_valid_ff && $stable(in_byte_ff), "input slot lost while blocked")
   `ASSERT_IMPLIES(a_full_stalls, in_valid_ff && out_valid_ff && rsp_stall, req_stall, "byte taken with both slots full")
   `ASSERT_NEXT(a_idle_drains, !in_valid_ff && (!out_valid_ff || !rsp_stall), !out_valid_ff, "result appeared without a step")

endmodule

`default_nettype wire

[tb/websocket_frame_parser_core_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// websocket_frame_parser_core_test
// Self-checking bench for the receive-side frame parser. Frames are sent as a
// byte stream with random idle gaps and result stalls. A scoreboard parses
// every accepted byte alongside the block and checks each result beat field
// by field in order.
// ----------------------------------------------------------------------------

module websocket_frame_parser_core_test;

   localparam int WATCHDOG_CYCLES = 2000;
   localparam int SETTLE_CYCLES   = 40;
   localparam int STREAM_BYTES    = 1300;
   localparam int IDLE_MAX        = 13;
   localparam int PRINT_LIMIT     = 40;

   // Frame opcodes used to build test frames, one of them reserved
   localparam logic [3:0] OP_CONT     = 4'h0;
   localparam logic [3:0] OP_TEXT     = 4'h1;
   localparam logic [3:0] OP_BINARY   = 4'h2;
   localparam logic [3:0] OP_CLOSE    = 4'h8;
   localparam logic [3:0] OP_PING     = 4'h9;
   localparam logic [3:0] OP_PONG     = 4'hA;
   localparam logic [3:0] OP_RESERVED = 4'hF;

   typedef enum logic [2:0] {
      PH_HEAD0,
      PH_HEAD1,
      PH_EXT_LEN,
      PH_KEY,
      PH_DATA
   } parse_phase_type;

   // -------------------------------------------------------------------------
   // Scoreboard: shadow frame parser plus the queue of payload beats it owes
   // -------------------------------------------------------------------------
   class frame_scoreboard;
      parse_phase_type      phase;
      logic [63:0]          remaining;
      logic [2:0]           hdr_left;
      logic [31:0]          key;
      logic [1:0]           key_idx;
      logic                 masked;
      logic                 fin;
      logic [3:0]           opcode;
      wsfp_pkg::result_type owed_beats[$];
      int                   error_count;

      function new();
         phase       = PH_HEAD0;
         remaining   = '0;
         hdr_left    = '0;
         key         = '0;
         key_idx     = '0;
         masked      = 1'b0;
         fin         = 1'b0;
         opcode      = '0;
         error_count = 0;
      endfunction

      function void owe_beat(logic [7:0] data, logic last, logic empty);
         wsfp_pkg::result_type beat;
         beat.valid          = 1'b1;
         beat.payload_byte   = data;
         beat.final_fragment = fin;
         beat.frame_opcode   = opcode;
         beat.end_of_frame   = last;
         beat.empty_frame    = empty;
         owed_beats = {owed_beats, beat};
      endfunction

      // Header over: enter payload, or owe the empty-frame beat
      function void close_header();
         key_idx = '0;
         if (remaining == '0) begin
            owe_beat(8'h00, 1'b1, 1'b1);
            phase = PH_HEAD0;
         end else begin
            phase = PH_DATA;
         end
      endfunction

      // Length known: collect the mask key first when masked
      function void close_length();
         if (masked) begin
            hdr_left = wsfp_pkg::KEY_BYTES_LEFT;
            key      = '0;
            phase    = PH_KEY;
         end else begin
            close_header();
         end
      endfunction

      function void note_byte(logic [7:0] b);
         logic [7:0] key_byte;
         int         shift;
         case (phase)
            PH_HEAD1: begin
               masked    = b[wsfp_pkg::MASK_BIT];
               remaining = '0;
               if (b[6:0] == wsfp_pkg::LEN_CODE_EXT16) begin
                  hdr_left = wsfp_pkg::EXT16_BYTES_LEFT;
                  phase    = PH_EXT_LEN;
               end else if (b[6:0] == wsfp_pkg::LEN_CODE_EXT64) begin
                  hdr_left = wsfp_pkg::EXT64_BYTES_LEFT;
                  phase    = PH_EXT_LEN;
               end else begin
                  remaining = 64'(b[6:0]);
                  close_length();
               end
            end
            PH_EXT_LEN: begin
               remaining = {remaining[55:0], b};
               if (hdr_left != '0) begin
                  hdr_left = hdr_left - 3'd1;
               end else begin
                  close_length();
               end
            end
            PH_KEY: begin
               key = {key[23:0], b};
               if (hdr_left != '0) begin
                  hdr_left = hdr_left - 3'd1;
               end else begin
                  close_header();
               end
            end
            PH_DATA: begin
               shift     = 24 - 8 * int'(key_idx);
               key_byte  = masked ? 8'(key >> shift) : 8'h00;
               key_idx   = key_idx + 2'd1;
               remaining = remaining - 64'd1;
               owe_beat(b ^ key_byte, remaining == '0, 1'b0);
               if (remaining == '0) begin
                  phase = PH_HEAD0;
               end
            end
            default: begin
               fin    = b[wsfp_pkg::FIN_BIT];
               opcode = b[3:0];
               phase  = PH_HEAD1;
            end
         endcase
      endfunction

      task report(string msg);
         error_count++;
         if (error_count <= PRINT_LIMIT) begin
            $display("[%0t] mismatch: %s", $time, msg);
         end
      endtask

      task check_beat(wsfp_pkg::result_type got);
         wsfp_pkg::result_type want;
         if (owed_beats.size() == 0) begin
            report($sformatf("beat with nothing owed, payload %02h", got.payload_byte));
            return;
         end
         want = owed_beats.pop_front();
         if (got.payload_byte !== want.payload_byte)
            report($sformatf("payload_byte %02h, want %02h", got.payload_byte, want.payload_byte));
         if (got.final_fragment !== want.final_fragment)
            report($sformatf("final_fragment %b, want %b",
                             got.final_fragment, want.final_fragment));
         if (got.frame_opcode !== want.frame_opcode)
            report($sformatf("frame_opcode %h, want %h", got.frame_opcode, want.frame_opcode));
         if (got.end_of_frame !== want.end_of_frame)
            report($sformatf("end_of_frame %b, want %b", got.end_of_frame, want.end_of_frame));
         if (got.empty_frame !== want.empty_frame)
            report($sformatf("empty_frame %b, want %b", got.empty_frame, want.empty_frame));
      endtask
   endclass

   // -------------------------------------------------------------------------
   // Clock, reset and block under test
   // -------------------------------------------------------------------------
   logic       clock       = 1'b0;
   logic       reset       = 1'b1;
   logic       req_valid   = 1'b0;
   logic [7:0] req_rx_byte = 8'h00;
   logic       rsp_stall   = 1'b0;
   logic       req_stall;
   logic       rsp_valid;
   logic [7:0] rsp_payload_byte;
   logic       rsp_final_fragment;
   logic [3:0] rsp_frame_opcode;
   logic       rsp_end_of_frame;
   logic       rsp_empty_frame;

   frame_scoreboard board;
   int idle_max    = 0;
   int bytes_sent  = 0;
   int idle_cycles = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   websocket_frame_parser_core DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_rx_byte        (req_rx_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_payload_byte   (rsp_payload_byte),
      .rsp_final_fragment (rsp_final_fragment),
      .rsp_frame_opcode   (rsp_frame_opcode),
      .rsp_end_of_frame   (rsp_end_of_frame),
      .rsp_empty_frame    (rsp_empty_frame)
   );

   // -------------------------------------------------------------------------
   // Byte stream driver
   // -------------------------------------------------------------------------
   function automatic int draw_gap();
      if ($urandom_range(0, 1) == 0) begin
         return 0;
      end
      return int'($urandom_range(0, idle_max));
   endfunction

   // Any byte whose low seven bits are not an extended-length code
   function automatic logic [7:0] short_code_byte();
      logic [7:0] b;
      do begin
         b = 8'($urandom);
      end while (b[6:0] == wsfp_pkg::LEN_CODE_EXT16 || b[6:0] == wsfp_pkg::LEN_CODE_EXT64);
      return b;
   endfunction

   // Hold off for a random gap, then present one beat until taken
   task automatic send_byte(input logic [7:0] value);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_byte(value);
      bytes_sent++;
   endtask

   task automatic send_frame(input logic [7:0] head0, input logic mask_bit,
                             input logic [6:0] code, input logic [63:0] length,
                             input logic [31:0] key, input int unsigned body_len);
      send_byte(head0);
      send_byte({mask_bit, code});
      if (code == wsfp_pkg::LEN_CODE_EXT16) begin
         for (int i = 1; i >= 0; i--) send_byte(length[8*i +: 8]);
      end else if (code == wsfp_pkg::LEN_CODE_EXT64) begin
         for (int i = 7; i >= 0; i--) send_byte(length[8*i +: 8]);
      end
      if (mask_bit) begin
         for (int i = 3; i >= 0; i--) send_byte(key[8*i +: 8]);
      end
      for (int n = 0; n < body_len; n++) send_byte(8'($urandom));
   endtask

   // Mostly short frames; some 16-bit and 64-bit lengths, non-minimal ones too
   task automatic send_random_frame();
      logic [7:0]  head0;
      logic [3:0]  op;
      logic [6:0]  code;
      logic [63:0] length;
      int unsigned pick;
      case ($urandom_range(0, 5))
         0:       op = OP_CONT;
         1:       op = OP_TEXT;
         2:       op = OP_BINARY;
         3:       op = OP_CLOSE;
         4:       op = OP_PING;
         default: op = OP_PONG;
      endcase
      head0 = ($urandom_range(0, 4) == 0) ? 8'($urandom) : {1'($urandom), 3'b000, op};
      pick  = $urandom_range(0, 99);
      if (pick < 60) begin
         length = 64'($urandom_range(0, 15));
         code   = length[6:0];
      end else if (pick < 75) begin
         length = 64'($urandom_range(0, 125));
         code   = length[6:0];
      end else if (pick < 92) begin
         length = ($urandom_range(0, 9) == 0) ? 64'($urandom_range(126, 700))
                                              : 64'($urandom_range(0, 300));
         code   = wsfp_pkg::LEN_CODE_EXT16;
      end else begin
         length = 64'($urandom_range(0, 40));
         code   = wsfp_pkg::LEN_CODE_EXT64;
      end
      send_frame(head0, 1'($urandom), code, length, $urandom, 32'(length));
   endtask

   // Broken sequence: random bytes, then filler until a frame boundary again
   task automatic send_noise();
      int unsigned burst;
      burst = $urandom_range(1, 8);
      for (int n = 0; n < burst; n++) send_byte(short_code_byte());
      while (board.phase != PH_HEAD0) send_byte(short_code_byte());
   endtask

   // -------------------------------------------------------------------------
   // Result sink: random stall before each beat, check on acceptance
   // -------------------------------------------------------------------------
   initial begin : result_sink
      int                   gap;
      wsfp_pkg::result_type got;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         gap = draw_gap();
         if (gap > 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (rsp_valid !== 1'b1) @(posedge clock);
         got.valid          = 1'b1;
         got.payload_byte   = rsp_payload_byte;
         got.final_fragment = rsp_final_fragment;
         got.frame_opcode   = rsp_frame_opcode;
         got.end_of_frame   = rsp_end_of_frame;
         got.empty_frame    = rsp_empty_frame;
         board.check_beat(got);
      end
   end

   // -------------------------------------------------------------------------
   // Watchdog: give up after a long stretch with no beat moving
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_CYCLES) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // -------------------------------------------------------------------------
   // Stimulus
   // -------------------------------------------------------------------------
   initial begin : stimulus
      board = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed frames, back to back
      idle_max = 0;
      // FIN, all reserved bits, top opcode; unmasked empty frame
      send_frame(8'hFF, 1'b0, 7'd0, 64'd0, 32'd0, 0);
      // masked empty frame: the result comes after the last key byte
      send_frame({1'b1, 3'b000, OP_PING}, 1'b1, 7'd0, 64'd0, 32'h1234_5678, 0);
      // masked text frame with a 16-bit length that fits in seven bits
      send_frame({1'b0, 3'b000, OP_TEXT}, 1'b1, wsfp_pkg::LEN_CODE_EXT16, 64'd2,
                 32'hFF00_FF00, 2);
      // close frame with a 64-bit length of zero
      send_frame({1'b1, 3'b000, OP_CLOSE}, 1'b0, wsfp_pkg::LEN_CODE_EXT64, 64'd0, 32'd0, 0);
      // reserved opcode, unmasked, one byte
      send_frame({1'b0, 3'b111, OP_RESERVED}, 1'b0, 7'd1, 64'd1, 32'd0, 1);

      // Random frames with some broken sequences; idle pattern varies per frame
      while (bytes_sent < STREAM_BYTES) begin
         idle_max = ($urandom_range(0, 3) == 0) ? 0 : IDLE_MAX;
         if ($urandom_range(0, 9) == 0) begin
            send_noise();
         end else begin
            send_random_frame();
         end
      end

      // Length with its top bit set: parsed as payload that never ends
      idle_max = IDLE_MAX;
      send_frame({1'b1, 3'b000, OP_BINARY}, 1'b1, wsfp_pkg::LEN_CODE_EXT64,
                 64'h8000_0000_0000_0005, $urandom, 24);
      req_valid <= 1'b0;

      // Drain, then let trailing beats show up
      while (board.owed_beats.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (board.error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
